### hdl/rbe_pkg.sv
// Shared constants, item types and header helper for the run-length byte encoder.
package rbe_pkg;

	localparam int MAX_LITERAL = 128;
	localparam int MAX_RUN     = 129;

	localparam int LIT_DEPTH = MAX_LITERAL + 1;
	localparam int CNT_W     = $clog2(LIT_DEPTH + 1);
	localparam int ADDR_W    = $clog2(LIT_DEPTH);
	localparam int RUN_W     = $clog2(MAX_RUN + 1);

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_stream;
	} in_t;

	typedef struct packed {
		logic [31:0] out_word;
		logic [2:0]  byte_count;
		logic        last;
	} out_t;

	// one coded byte on its way to the word packer
	typedef struct packed {
		logic       valid;
		logic [7:0] data;
		logic       last;
	} pbyte_t;

	function automatic logic [7:0] run_hdr(input logic [RUN_W-1:0] len);
		logic [7:0] k;
		k = 8'(len) - 8'd2;
		return 8'h80 | {1'b0, k[6:0]};
	endfunction

endpackage

### hdl/rbe_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rbe_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 129
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

### hdl/rbe_pack.sv
// Packs coded bytes four to a word (fewer on a last byte) into an output register.
module rbe_pack (
	input  logic           clk,
	input  logic           arst_n,
	input  rbe_pkg::pbyte_t byte_in,
	output logic           byte_ready,
	output logic           out_valid,
	input  logic           out_ready,
	output rbe_pkg::out_t  out_item
);

	logic [31:0] acc_q;
	logic [1:0]  acc_cnt_q;
	logic        out_valid_q;
	rbe_pkg::out_t out_item_q;

	logic        complete;
	logic        out_free;
	logic        take;
	logic [31:0] merged;

	assign complete   = (acc_cnt_q == 2'd3) || byte_in.last;
	assign out_free   = !out_valid_q || out_ready;
	assign byte_ready = !complete || out_free;
	assign take       = byte_in.valid && byte_ready;
	assign merged     = acc_q | ({24'b0, byte_in.data} << {acc_cnt_q, 3'b000});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			acc_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else if (take && complete) begin
			acc_q       <= '0;
			acc_cnt_q   <= '0;
			out_valid_q <= 1'b1;
		end else begin
			if (take) begin
				acc_q     <= merged;
				acc_cnt_q <= acc_cnt_q + 2'd1;
			end
			if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && complete) begin
			out_item_q.out_word   <= merged;
			out_item_q.byte_count <= {1'b0, acc_cnt_q} + 3'd1;
			out_item_q.last       <= byte_in.last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

endmodule

### hdl/rle_byte_encoder_core.sv
// Run-length byte encoder: mode control, literal buffer RAM and coded byte sequencer.
// An item that emits nothing leaves the sequencer idle, so in_ready stays high for the next item.
// A run emits its 2 coded bytes, header then value; a literal flush emits header plus bytes at one
// byte a cycle (up to 131 bytes, 33 words), then the buffer writes ST_WR0 and ST_WR1 after a full block.
// Throughput is one byte per cycle through the sequencer; out_ready stalls it.
// Reset clears mode, counts and handshake state; the literal RAM is not cleared.
module rle_byte_encoder_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  rbe_pkg::in_t  in_item,
	output logic          out_valid,
	input  logic          out_ready,
	output rbe_pkg::out_t out_item
);

	localparam int CNT_W  = rbe_pkg::CNT_W;
	localparam int ADDR_W = rbe_pkg::ADDR_W;
	localparam int RUN_W  = rbe_pkg::RUN_W;

	// sequencer states
	localparam logic [2:0] ST_IDLE     = 3'd0;
	localparam logic [2:0] ST_RUN_HDR  = 3'd1;
	localparam logic [2:0] ST_RUN_VAL  = 3'd2;
	localparam logic [2:0] ST_LIT_HDR  = 3'd3;
	localparam logic [2:0] ST_LIT_BYTE = 3'd4;
	localparam logic [2:0] ST_WR0      = 3'd5;
	localparam logic [2:0] ST_WR1      = 3'd6;

	// encoder state
	logic [2:0]       state_q;
	logic             run_mode_q;
	logic [CNT_W-1:0] lit_cnt_q;
	logic [RUN_W-1:0] run_len_q;
	logic [7:0]       run_val_q;
	logic [7:0]       last_q;     // copy of the pending (newest) literal
	logic [7:0]       hold_q;     // old pending literal, rewritten after a full block
	logic [7:0]       em_hdr_q;   // run header byte being emitted

	// literal sequencer
	logic [CNT_W-1:0]  lit_rem_q;  // literals not yet placed in a block
	logic [CNT_W-1:0]  blk_rem_q;  // bytes left in the current block
	logic [ADDR_W-1:0] pos_q;      // next RAM entry to send
	logic              wr_pend_q;  // buffer rewrite owed after the flush

	// input decode
	logic       in_fire;
	logic [7:0] b;
	logic       eos;
	logic       same_run;
	logic       same_lit;
	logic       lit_full;
	logic [RUN_W-1:0] run_inc;

	assign in_ready = (state_q == ST_IDLE);
	assign in_fire  = in_valid && in_ready;
	assign b        = in_item.data_byte;
	assign eos      = in_item.end_of_stream;
	assign same_run = (b == run_val_q);
	assign same_lit = (b == last_q);
	assign lit_full = (lit_cnt_q == CNT_W'(rbe_pkg::LIT_DEPTH));
	assign run_inc  = run_len_q + RUN_W'(1);

	// coded byte stream toward the packer
	rbe_pkg::pbyte_t emb;
	logic            emb_ready;
	logic            emb_take;
	logic [7:0]      rd_data;
	logic [CNT_W-1:0] blk_len;

	assign blk_len  = (lit_rem_q > CNT_W'(rbe_pkg::MAX_LITERAL)) ?
	                  CNT_W'(rbe_pkg::MAX_LITERAL) : lit_rem_q;
	assign emb_take = emb.valid && emb_ready;

	always_comb begin
		emb = '0;
		unique case (state_q)
			ST_RUN_HDR: begin
				emb.valid = 1'b1;
				emb.data  = em_hdr_q;
			end
			ST_RUN_VAL: begin
				emb.valid = 1'b1;
				emb.data  = run_val_q;
				emb.last  = 1'b1;
			end
			ST_LIT_HDR: begin
				emb.valid = 1'b1;
				emb.data  = 8'(blk_len - CNT_W'(1));
			end
			ST_LIT_BYTE: begin
				emb.valid = 1'b1;
				emb.data  = rd_data;
				emb.last  = (blk_rem_q == CNT_W'(1)) && (lit_rem_q == '0);
			end
			default: begin
				emb = '0;
			end
		endcase
	end

	// literal RAM ports
	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;
	logic [7:0]        wr_data;
	logic              rd_en;
	logic [ADDR_W-1:0] rd_addr;

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = '0;
		wr_data = b;
		if (state_q == ST_WR0) begin
			wr_en   = 1'b1;
			wr_data = hold_q;
		end else if (state_q == ST_WR1) begin
			wr_en   = 1'b1;
			wr_addr = ADDR_W'(1);
			wr_data = last_q;
		end else if (in_fire && !eos) begin
			if (run_mode_q) begin
				// run broken: new byte becomes the first literal
				wr_en = !same_run;
			end else if (lit_cnt_q == '0) begin
				wr_en = 1'b1;
			end else if (!same_lit && !lit_full) begin
				wr_en   = 1'b1;
				wr_addr = lit_cnt_q[ADDR_W-1:0];
			end
		end
	end

	// prefetch: the header reads the block's first byte, each byte reads the next one
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = pos_q;
		if (emb_take && state_q == ST_LIT_HDR) begin
			rd_en = 1'b1;
		end else if (emb_take && state_q == ST_LIT_BYTE && blk_rem_q != CNT_W'(1)) begin
			rd_en   = 1'b1;
			rd_addr = pos_q + ADDR_W'(1);
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			run_mode_q <= 1'b0;
			lit_cnt_q  <= '0;
			run_len_q  <= '0;
			lit_rem_q  <= '0;
			blk_rem_q  <= '0;
			pos_q      <= '0;
			wr_pend_q  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						if (eos) begin
							// flush whatever is pending
							if (run_mode_q) begin
								state_q <= ST_RUN_HDR;
							end else if (lit_cnt_q != '0) begin
								lit_rem_q <= lit_cnt_q;
								pos_q     <= '0;
								wr_pend_q <= 1'b0;
								state_q   <= ST_LIT_HDR;
							end
							run_mode_q <= 1'b0;
							run_len_q  <= '0;
							lit_cnt_q  <= '0;
						end else if (run_mode_q) begin
							if (same_run) begin
								if (run_inc == RUN_W'(rbe_pkg::MAX_RUN)) begin
									// longest run: send it and drop back to literals
									state_q    <= ST_RUN_HDR;
									run_mode_q <= 1'b0;
									run_len_q  <= '0;
									lit_cnt_q  <= '0;
								end else begin
									run_len_q <= run_inc;
								end
							end else begin
								state_q    <= ST_RUN_HDR;
								run_mode_q <= 1'b0;
								run_len_q  <= '0;
								lit_cnt_q  <= CNT_W'(1);
							end
						end else if (lit_cnt_q == '0) begin
							lit_cnt_q <= CNT_W'(1);
						end else if (same_lit) begin
							// repeat of the pending literal: earlier literals go out, run of 2
							if (lit_cnt_q != CNT_W'(1)) begin
								lit_rem_q <= lit_cnt_q - CNT_W'(1);
								pos_q     <= '0;
								wr_pend_q <= 1'b0;
								state_q   <= ST_LIT_HDR;
							end
							run_mode_q <= 1'b1;
							run_len_q  <= RUN_W'(2);
							lit_cnt_q  <= '0;
						end else if (!lit_full) begin
							lit_cnt_q <= lit_cnt_q + CNT_W'(1);
						end else begin
							// buffer full: one full block out, pending and new byte kept
							lit_rem_q <= CNT_W'(rbe_pkg::MAX_LITERAL);
							pos_q     <= '0;
							wr_pend_q <= 1'b1;
							state_q   <= ST_LIT_HDR;
							lit_cnt_q <= CNT_W'(2);
						end
					end
				end
				ST_RUN_HDR: begin
					if (emb_take) begin
						state_q <= ST_RUN_VAL;
					end
				end
				ST_RUN_VAL: begin
					if (emb_take) begin
						state_q <= ST_IDLE;
					end
				end
				ST_LIT_HDR: begin
					if (emb_take) begin
						blk_rem_q <= blk_len;
						lit_rem_q <= lit_rem_q - blk_len;
						state_q   <= ST_LIT_BYTE;
					end
				end
				ST_LIT_BYTE: begin
					if (emb_take) begin
						pos_q     <= pos_q + ADDR_W'(1);
						blk_rem_q <= blk_rem_q - CNT_W'(1);
						if (blk_rem_q == CNT_W'(1)) begin
							if (lit_rem_q != '0) begin
								state_q <= ST_LIT_HDR;
							end else if (wr_pend_q) begin
								state_q <= ST_WR0;
							end else begin
								state_q <= ST_IDLE;
							end
						end
					end
				end
				ST_WR0: begin
					state_q <= ST_WR1;
				end
				ST_WR1: begin
					wr_pend_q <= 1'b0;
					state_q   <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// byte registers, only meaningful once written
	always_ff @(posedge clk) begin
		if (in_fire && !eos) begin
			if (run_mode_q) begin
				if (!same_run) begin
					last_q <= b;
				end
			end else if (lit_cnt_q == '0) begin
				last_q <= b;
			end else if (same_lit) begin
				run_val_q <= b;
			end else begin
				if (lit_full) begin
					hold_q <= last_q;
				end
				last_q <= b;
			end
		end
		if (in_fire) begin
			// header for a run sent by this item
			if (!eos && run_mode_q && same_run) begin
				em_hdr_q <= rbe_pkg::run_hdr(run_inc);
			end else begin
				em_hdr_q <= rbe_pkg::run_hdr(run_len_q);
			end
		end
	end

	rbe_ram #(
		.WIDTH (8),
		.DEPTH (rbe_pkg::LIT_DEPTH)
	) u_lit_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	rbe_pack u_pack (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_in    (emb),
		.byte_ready (emb_ready),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_item   (out_item)
	);

endmodule

### dv/tb_rle_byte_encoder_core.sv
// Self-checking testbench for the run-length byte encoder core.
`timescale 1ns / 1ps

module tb_rle_byte_encoder_core;

	// generous ceiling; a correct run needs a small fraction of this
	localparam int CYCLE_LIMIT = 500000;
	// longest coded burst is 131 bytes
	localparam int SETTLE_CYCLES = 160;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	rbe_pkg::in_t in_item = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	rbe_pkg::out_t out_item;

	// idle rates in percent, changed per phase by the main sequence
	int tx_gap_pct = 0;
	int rx_stall_pct = 0;
	// long receiver hold-off: main posts a length, the receiver process counts it down
	int hold_request = 0;
	int hold_left = 0;

	int fail_count = 0;
	int cycle_count = 0;

	// predictor state: mirrors the encoder's mode, literal buffer and run counter
	logic pend_run = 1'b0;
	logic [7:0] lit_buf [0:rbe_pkg::MAX_LITERAL];
	int lit_fill = 0;
	logic [7:0] run_byte = '0;
	int run_len = 0;

	logic [7:0] coded_bytes [$];	// coded bytes of the item being predicted
	rbe_pkg::out_t coded_words [$];	// expected output words, oldest first
	logic [7:0] prev_byte = '0;	// last data byte sent, for building random streams

	rle_byte_encoder_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item(out_item)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	function automatic void queue_byte(input logic [7:0] v);
		coded_bytes = {coded_bytes, v};
	endfunction

	function automatic void queue_word(input rbe_pkg::out_t w);
		coded_words = {coded_words, w};
	endfunction

	// Literal blocks for the first n buffered bytes: each a header of its length minus 1, then its bytes.
	// More than MAX_LITERAL (n is capped at MAX_LITERAL + 1) give one full block with the remainder last.
	function automatic void put_literal_blocks(input int n);
		int pos;
		int c;
		pos = 0;
		if (n > rbe_pkg::MAX_LITERAL + 1)
			n = rbe_pkg::MAX_LITERAL + 1;
		while (n > 0) begin
			c = (n > rbe_pkg::MAX_LITERAL) ? rbe_pkg::MAX_LITERAL : n;
			queue_byte(8'(c - 1));
			for (int i = 0; i < c; i++)
				queue_byte(lit_buf[pos + i]);
			pos += c;
			n -= c;
		end
	endfunction

	// Run block: header 0x80 | (run_len-2), then the repeated value.
	function automatic void put_run_pair();
		logic [7:0] k;
		k = 8'((run_len >= 2) ? run_len - 2 : 0);
		queue_byte(8'h80 | {1'b0, k[6:0]});
		queue_byte(run_byte);
	endfunction

	// Advance the predictor by one accepted item and queue the words it yields.
	function automatic void encode_item(input rbe_pkg::in_t it);
		logic [7:0] b;
		logic [7:0] prev;
		rbe_pkg::out_t w;
		int cnt;
		b = it.data_byte;
		coded_bytes.delete();
		if (it.end_of_stream) begin
			// flush whatever is pending; an empty flush yields nothing
			if (pend_run)
				put_run_pair();
			else if (lit_fill > 0)
				put_literal_blocks(lit_fill);
			pend_run = 1'b0;
			run_len = 0;
			lit_fill = 0;
		end else if (pend_run) begin
			if (b == run_byte) begin
				run_len++;
				// full run goes out at once, back to an empty literal buffer
				if (run_len >= rbe_pkg::MAX_RUN) begin
					put_run_pair();
					pend_run = 1'b0;
					run_len = 0;
					lit_fill = 0;
				end
			end else begin
				// run broken: the new byte opens a fresh literal buffer
				put_run_pair();
				pend_run = 1'b0;
				run_len = 0;
				lit_buf[0] = b;
				lit_fill = 1;
			end
		end else if (lit_fill == 0) begin
			lit_buf[0] = b;
			lit_fill = 1;
		end else begin
			prev = lit_buf[lit_fill - 1];
			if (b == prev) begin
				// repeat of the pending literal: older literals out, run of two starts
				put_literal_blocks(lit_fill - 1);
				pend_run = 1'b1;
				run_byte = b;
				run_len = 2;
				lit_fill = 0;
			end else if (lit_fill < rbe_pkg::MAX_LITERAL + 1) begin
				lit_buf[lit_fill] = b;
				lit_fill++;
			end else begin
				// buffer full: first MAX_LITERAL go out, last one and new byte stay
				put_literal_blocks(rbe_pkg::MAX_LITERAL);
				lit_buf[0] = prev;
				lit_buf[1] = b;
				lit_fill = 2;
			end
		end
		// pack four bytes per word, first byte in the low lane
		for (int k = 0; k < coded_bytes.size(); k += 4) begin
			cnt = coded_bytes.size() - k;
			if (cnt > 4)
				cnt = 4;
			w = '0;
			for (int i = 0; i < cnt; i++)
				w.out_word[8*i +: 8] = coded_bytes[k + i];
			w.byte_count = 3'(cnt);
			w.last = (k + 4 >= coded_bytes.size());
			queue_word(w);
		end
	endfunction

	// ------------------------------------------------------------------
	// Receiver side: random stalls plus an occasional long hold-off
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (hold_request > 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left--;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
		end
	end

	// Every accepted output word is compared with the oldest expectation.
	always @(posedge clk) begin : word_check
		rbe_pkg::out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (coded_words.size() == 0) begin
				$error("unexpected word: out_word=%h byte_count=%0d last=%0d",
					out_item.out_word, out_item.byte_count, out_item.last);
				fail_count++;
			end else begin
				want = coded_words.pop_front();
				if (out_item.out_word !== want.out_word) begin
					$error("out_word: expected %h, got %h", want.out_word, out_item.out_word);
					fail_count++;
				end
				if (out_item.byte_count !== want.byte_count) begin
					$error("byte_count: expected %0d, got %0d",
						want.byte_count, out_item.byte_count);
					fail_count++;
				end
				if (out_item.last !== want.last) begin
					$error("last: expected %0d, got %0d", want.last, out_item.last);
					fail_count++;
				end
			end
		end
	end

	// Watchdog: a hung handshake ends the run as a failure.
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// ------------------------------------------------------------------
	// Sender side
	// ------------------------------------------------------------------

	// Offer one item; entered and left at a falling edge. Valid stays high after
	// acceptance so back-to-back items need no drop; idle gaps lower it.
	task automatic send_item(input logic [7:0] b, input logic eos);
		rbe_pkg::in_t it;
		it.data_byte = b;
		it.end_of_stream = eos;
		while ($urandom_range(0, 99) < tx_gap_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_item <= it;
		do
			@(posedge clk);
		while (!in_ready);
		encode_item(it);
		if (!eos)
			prev_byte = b;
		@(negedge clk);
	endtask

	// Sender stops and waits until every expected word has come back.
	task automatic wait_coded_drained();
		in_valid <= 1'b0;
		while (coded_words.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Extreme byte values, end items with and without pending data.
	task automatic test_field_extremes();
		send_item(8'h00, 1'b0);
		send_item(8'hFF, 1'b0);
		send_item(8'h00, 1'b0);
		send_item(8'hFF, 1'b1);	// flush of three literals
		send_item(8'h00, 1'b1);	// nothing pending: no words
		send_item(8'hFF, 1'b1);
		send_item(8'hFF, 1'b0);	// single literal flushed
		send_item(8'h00, 1'b1);
	endtask

	// Repeat of the pending literal, run broken, end while in a run.
	task automatic test_repeat_and_break();
		send_item(8'h11, 1'b0);
		send_item(8'h22, 1'b0);
		send_item(8'h22, 1'b0);	// emits literal 0x11, run of two starts
		send_item(8'h22, 1'b0);
		send_item(8'h33, 1'b0);	// run broken, 0x33 buffered
		send_item(8'h00, 1'b1);
		send_item(8'h80, 1'b0);
		send_item(8'h80, 1'b0);	// repeat with no literals before it
		send_item(8'h7F, 1'b1);	// end flushes the run
		send_item(8'h55, 1'b0);
		send_item(8'hAA, 1'b0);
		send_item(8'hAA, 1'b0);
		send_item(8'h55, 1'b0);
		send_item(8'hAA, 1'b1);
	endtask

	// Run reaching the maximum is emitted on its own; the bytes after it restart.
	task automatic test_full_run();
		for (int i = 0; i < rbe_pkg::MAX_RUN + 2; i++)
			send_item(8'h5A, 1'b0);
		send_item(8'h00, 1'b1);
	endtask

	// Literal buffer overflow, then refill to a full buffer so the end flush
	// splits into a full block and a one-byte block.
	task automatic test_literal_overflow();
		for (int i = 0; i < rbe_pkg::MAX_LITERAL + 2; i++)
			send_item(8'(i), 1'b0);
		for (int i = 0; i < rbe_pkg::MAX_LITERAL - 1; i++)
			send_item(8'(255 - i), 1'b0);
		send_item(8'h00, 1'b1);
	endtask

	// Receiver holds off for a long stretch while items keep coming, so the
	// encoder fills up and drops in_ready. Byte pairs make short runs that
	// produce words early.
	task automatic test_output_backpressure();
		hold_request = 200;
		for (int i = 0; i < 40; i++)
			send_item(8'((i >> 1) * 7 + 1), 1'b0);
		send_item(8'h00, 1'b1);
		wait_coded_drained();
	endtask

	// Random stream of short runs, literal stretches, end items and stray bytes.
	task automatic test_random_stream(input int n_items);
		int sent;
		int kind;
		int len;
		logic [7:0] b;
		sent = 0;
		while (sent < n_items) begin
			kind = $urandom_range(0, 99);
			if (kind < 45) begin
				len = $urandom_range(2, 6);
				b = 8'($urandom);
				for (int i = 0; i < len; i++)
					send_item(b, 1'b0);
				sent += len;
			end else if (kind < 85) begin
				// literal stretch with no equal neighbors
				len = $urandom_range(1, 10);
				for (int i = 0; i < len; i++)
					send_item(prev_byte + 8'($urandom_range(1, 255)), 1'b0);
				sent += len;
			end else if (kind < 95) begin
				send_item(8'($urandom), 1'b1);
				sent++;
			end else begin
				send_item(8'($urandom), 1'b0);
				sent++;
			end
		end
		send_item(8'($urandom), 1'b1);
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// phase one: sender idles a little, receiver a lot
		tx_gap_pct = 21;
		rx_stall_pct = 70;
		test_field_extremes();
		test_repeat_and_break();
		test_full_run();
		test_random_stream(14);
		wait_coded_drained();

		// phase two: roles swapped
		tx_gap_pct = 70;
		rx_stall_pct = 21;
		test_output_backpressure();
		test_literal_overflow();
		wait_coded_drained();

		// phase three: full speed on both sides
		tx_gap_pct = 0;
		rx_stall_pct = 0;
		test_random_stream(14);

		// let stray words show up before judging
		wait_coded_drained();
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (coded_words.size() != 0) begin
			$error("%0d expected words never arrived", coded_words.size());
			fail_count++;
		end
		if (fail_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
